// ===== design/bsms_pkg.sv =====
// shared types, codes and helpers for the bit-slice microcode step unit
package bsms_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        FN_ADD  = 3'd0,
        FN_SUBR = 3'd1,
        FN_SUBS = 3'd2,
        FN_OR   = 3'd3,
        FN_AND  = 3'd4,
        FN_NOTRS = 3'd5,
        FN_XOR  = 3'd6,
        FN_XNOR = 3'd7
    } t_alu_fn;

    typedef enum logic [2:0] {
        DST_QREG = 3'd0,
        DST_NOP  = 3'd1,
        DST_RAMA = 3'd2,
        DST_RAMF = 3'd3,
        DST_RAMQD = 3'd4,
        DST_RAMD = 3'd5,
        DST_RAMQU = 3'd6,
        DST_RAMU = 3'd7
    } t_dest;

    localparam logic [2:0] SRC_AQ = 3'd0;
    localparam logic [2:0] SRC_AB = 3'd1;
    localparam logic [2:0] SRC_ZQ = 3'd2;
    localparam logic [2:0] SRC_ZB = 3'd3;
    localparam logic [2:0] SRC_ZA = 3'd4;
    localparam logic [2:0] SRC_DA = 3'd5;
    localparam logic [2:0] SRC_DQ = 3'd6;
    localparam logic [2:0] SRC_DZ = 3'd7;

    localparam logic [15:0] HI_MASK = 16'hFF00;
    localparam logic [15:0] LO_MASK = 16'h00FF;

    // decoded microword plus the step's data
    typedef struct packed {
        logic [3:0]  a_idx;
        logic [3:0]  b_idx;
        logic        i2_hi;
        logic        i2_lo;
        logic [1:0]  i10;
        logic        stall;
        t_alu_fn     func;
        logic        ldab;
        t_dest       dest;
        logic        sgn;
        logic        jmp;
        logic        mult;
        logic        cin;
        logic [15:0] d_bus;
        logic        start_req;
        logic [7:0]  start_addr;
    } t_uop;

    // queue handshake between the front and back parts
    typedef struct packed {
        logic push;
        logic full;
    } t_q_in;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_q_out;

    // operand pair {r, s} for one source code
    function automatic logic [31:0] sel_ops(input logic [2:0] code, input logic [15:0] av,
                                            input logic [15:0] bv, input logic [15:0] dv,
                                            input logic [15:0] qv);
        logic [15:0] r;
        logic [15:0] s;
        r = '0;
        s = '0;
        case (code)
            SRC_AQ: begin r = av; s = qv; end
            SRC_AB: begin r = av; s = bv; end
            SRC_ZQ: begin r = '0; s = qv; end
            SRC_ZB: begin r = '0; s = bv; end
            SRC_ZA: begin r = '0; s = av; end
            SRC_DA: begin r = dv; s = av; end
            SRC_DQ: begin r = dv; s = qv; end
            SRC_DZ: begin r = dv; s = '0; end
            default: begin r = '0; s = '0; end
        endcase
        return {r, s};
    endfunction

endpackage

// ===== design/bit_slice_microcode_step_unit.sv =====
// top level: 16-bit bit-slice microcode step unit
//
//  port group  dir  contents
//  s_axis      in   tdata: micro_word[23:0], data_byte[31:24], start_address[39:32];
//                   tuser: start_req
//  m_axis      out  tdata: y_value[15:0], next_address[23:16]; tlast: stall_res
//
// one word per cycle sustained while the output is not stalled; an accepted word passes
// through the queue write, the register file read, then the alu and destination write
// the register file read is registered, with a bypass of the write made on the same edge
// i_rst_n is synchronous; working registers read as zero until first written
// a stalled output stops the back part; the queue keeps taking words until full
module bit_slice_microcode_step_unit
    import bsms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // micro_word, data_byte, start_address
    input  logic        s_axis_tuser,  // start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // y_value, next_address
    output logic        m_axis_tlast
);

    t_q_in          q_in;
    t_q_out         q_out;
    t_uop           front_uop;
    t_uop           head_uop;
    logic           q_full;
    logic           q_valid;
    logic [QCW-1:0] q_count;

    bsms_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_q_in        (q_in),
        .o_uop         (front_uop)
    );

    bsms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_in.push),
        .i_uop   (front_uop),
        .i_pop   (q_out.pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_uop   (head_uop),
        .o_count (q_count)
    );

    bsms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_uop       (head_uop),
        .o_q_out       (q_out),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // queue never pushed when full and never above its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_in.push |-> !q_in.full) and (q_count <= QCW'(QDEPTH)))
        else $error("queue overflow");

    // a pop only happens with an entry present
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_out.pop |-> q_out.valid)
        else $error("pop from empty queue");

    // an accepted word into an empty pipe is not lost but reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && q_count == '0 && !m_axis_tvalid)
        |=> ##2 m_axis_tvalid)
        else $error("word lost in pipe");

endmodule

// ===== design/bsms_front.sv =====
// front part: takes input words and decodes the microword
module bsms_front
    import bsms_pkg::*;
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        i_q_full,
    output t_q_in       o_q_in,
    output t_uop        o_uop
);

    logic [23:0] w;

    assign w             = s_axis_tdata[23:0];
    assign s_axis_tready = !i_q_full;
    assign o_q_in.push   = s_axis_tvalid && !i_q_full;
    assign o_q_in.full   = i_q_full;

    always_comb begin
        o_uop.a_idx      = w[23:20];
        o_uop.b_idx      = w[19:16];
        o_uop.i2_hi      = w[15];
        o_uop.i2_lo      = w[14];
        o_uop.i10        = w[13:12];
        o_uop.stall      = w[11];
        o_uop.func       = t_alu_fn'(w[10:8]);
        o_uop.ldab       = w[7];
        o_uop.dest       = t_dest'(w[6:4]);
        o_uop.sgn        = w[3];
        o_uop.jmp        = w[2];
        o_uop.mult       = w[1];
        o_uop.cin        = w[0];
        // byte copied to both halves of the d bus
        o_uop.d_bus      = {s_axis_tdata[31:24], s_axis_tdata[31:24]};
        o_uop.start_req  = s_axis_tuser;
        o_uop.start_addr = s_axis_tdata[39:32];
    end

endmodule

// ===== design/bsms_queue.sv =====
// short queue of decoded words between front and back
module bsms_queue
    import bsms_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_uop   i_uop,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_uop   o_uop,
    output logic [QCW-1:0] o_count
);

    t_uop           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_uop   = r_mem[r_rp];
    assign o_count = r_cnt;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_uop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/bsms_back.sv =====
// back part: register file read, alu, destinations and sequencer
module bsms_back
    import bsms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_uop        i_q_uop,
    output t_q_out      o_q_out,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    // register file: one write port, two registered reads, write-first bypass
    logic [15:0] mem [16];
    logic [15:0] r_rf_vld;

    logic        pop;
    logic        b_exec;
    logic        r_b_valid;
    t_uop        r_b;
    logic [15:0] r_a_mem, r_b_mem;
    logic        r_a_byp, r_b_byp, r_a_zero, r_b_zero;
    logic [15:0] r_byp_data;

    logic [15:0] r_q;
    logic [7:0]  r_jl;
    logic        r_q0;
    logic [7:0]  r_pc;

    logic        r_out_valid;
    logic [15:0] r_out_y;
    logic [7:0]  r_out_pc;
    logic        r_out_stall;

    logic        wr_en;
    logic [15:0] wr_data;
    logic [15:0] av, bv;
    logic [1:0]  i10_eff;
    logic [31:0] ops_hi, ops_lo;
    logic [15:0] rr_w, ss_w, f;
    logic        ovr, msb;
    logic [7:0]  pc_base, jl_next, pc_next;
    logic [15:0] q_next, y_next;
    logic        q0_next;

    assign b_exec  = r_b_valid && (!r_out_valid || m_axis_tready);
    assign pop     = i_q_valid && (!r_b_valid || b_exec);
    assign o_q_out.valid = i_q_valid;
    assign o_q_out.pop   = pop;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_b.b_idx] <= wr_data;
        end
        if (pop) begin
            r_a_mem <= mem[i_q_uop.a_idx];
            r_b_mem <= mem[i_q_uop.b_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b        <= i_q_uop;
            r_byp_data <= wr_data;
            r_a_byp    <= wr_en && (r_b.b_idx == i_q_uop.a_idx);
            r_b_byp    <= wr_en && (r_b.b_idx == i_q_uop.b_idx);
            r_a_zero   <= !r_rf_vld[i_q_uop.a_idx];
            r_b_zero   <= !r_rf_vld[i_q_uop.b_idx];
        end
    end

    assign av = r_a_byp ? r_byp_data : (r_a_zero ? 16'h0000 : r_a_mem);
    assign bv = r_b_byp ? r_byp_data : (r_b_zero ? 16'h0000 : r_b_mem);

    // multiply step flips i1 when the latched q0 is clear
    assign i10_eff = r_b.i10 ^ {r_b.mult & ~r_q0, 1'b0};
    assign ops_hi  = sel_ops({r_b.i2_hi, i10_eff}, av, bv, r_b.d_bus, r_q);
    assign ops_lo  = sel_ops({r_b.i2_lo, i10_eff}, av, bv, r_b.d_bus, r_q);
    assign rr_w    = (ops_hi[31:16] & HI_MASK) | (ops_lo[31:16] & LO_MASK);
    assign ss_w    = (ops_hi[15:0] & HI_MASK) | (ops_lo[15:0] & LO_MASK);

    // four nibble slices with rippled carry
    always_comb begin
        logic       c;
        logic [3:0] r4, s4, ra, sa, f4;
        logic [4:0] sum;
        logic [3:0] low3;
        logic       c4;
        c   = r_b.cin;
        ovr = 1'b0;
        f   = '0;
        for (int k = 0; k < 4; k++) begin
            r4   = rr_w[4*k +: 4];
            s4   = ss_w[4*k +: 4];
            ra   = (r_b.func == FN_SUBR) ? ~r4 : r4;
            sa   = (r_b.func == FN_SUBS) ? ~s4 : s4;
            sum  = 5'(ra) + 5'(sa) + 5'(c);
            low3 = 4'(ra[2:0]) + 4'(sa[2:0]) + 4'(c);
            f4   = '0;
            c4   = 1'b0;
            case (r_b.func)
                FN_ADD, FN_SUBR, FN_SUBS: begin
                    f4  = sum[3:0];
                    c4  = sum[4];
                    ovr = low3[3] ^ sum[4];
                end
                FN_OR: begin
                    f4  = r4 | s4;
                    c4  = (f4 != 4'hF) | c;
                    ovr = c4;
                end
                FN_AND: begin
                    f4  = r4 & s4;
                    c4  = (f4 != 4'h0) | c;
                    ovr = c4;
                end
                FN_NOTRS: begin
                    f4  = ~r4 & s4;
                    c4  = (f4 != 4'h0) | c;
                    ovr = c4;
                end
                FN_XOR: begin
                    f4  = r4 ^ s4;
                    ovr = 1'b0;
                end
                FN_XNOR: begin
                    f4  = ~(r4 ^ s4);
                    ovr = 1'b0;
                end
                default: begin
                    f4  = '0;
                    ovr = 1'b0;
                end
            endcase
            f[4*k +: 4] = f4;
            c = c4;
        end
    end

    assign msb = r_b.sgn & (ovr ^ f[15]);

    always_comb begin
        wr_en   = b_exec;
        wr_data = f;
        q_next  = r_q;
        q0_next = r_q0;
        y_next  = f;
        case (r_b.dest)
            DST_QREG: begin
                wr_en  = 1'b0;
                q_next = f;
            end
            DST_NOP: wr_en = 1'b0;
            DST_RAMA: y_next = av;
            DST_RAMF: wr_data = f;
            DST_RAMQD: begin
                wr_data = {msb, f[15:1]};
                q0_next = r_q[0];
                q_next  = {f[0], r_q[15:1]};
            end
            DST_RAMD: begin
                wr_data = {msb, f[15:1]};
                q0_next = r_q[0];
            end
            DST_RAMQU: begin
                wr_data = {f[14:0], r_q[15]};
                q_next  = {r_q[14:0], 1'b0};
                q0_next = 1'b0;
            end
            DST_RAMU: begin
                wr_data = {f[14:0], 1'b0};
                q0_next = 1'b0;
            end
            default: wr_en = 1'b0;
        endcase
    end

    assign pc_base = r_b.start_req ? r_b.start_addr : r_pc;
    assign jl_next = r_b.ldab ? {r_b.a_idx, r_b.b_idx} : r_jl;
    assign pc_next = (r_b.jmp && !msb) ? jl_next : (pc_base + 8'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_rf_vld    <= '0;
            r_q         <= '0;
            r_jl        <= '0;
            r_q0        <= 1'b1;
            r_pc        <= '0;
        end else begin
            if (pop) begin
                r_b_valid <= 1'b1;
            end else if (b_exec) begin
                r_b_valid <= 1'b0;
            end
            if (b_exec) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_rf_vld[r_b.b_idx] <= 1'b1;
            end
            if (b_exec) begin
                r_q  <= q_next;
                r_q0 <= q0_next;
                r_jl <= jl_next;
                r_pc <= pc_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_exec) begin
            r_out_y     <= y_next;
            r_out_pc    <= pc_next;
            r_out_stall <= r_b.stall;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pc, r_out_y};
    assign m_axis_tlast  = r_out_stall;

endmodule
